// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RPM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rpm_pkg.sv =====
`timescale 1ns / 1ps
package rpm_pkg;

  localparam int MOD_BITS      = 9;
  localparam int EXP_BITS      = 8;
  localparam int IDX_BITS      = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [MOD_BITS-1:0] MODULUS_RESET  = 9'd253;
  localparam logic [EXP_BITS-1:0] EXPONENT_RESET = 8'd13;
  localparam logic [IDX_BITS-1:0] BIT_IDX_TOP    = 3'd7;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } rpm_state_t;

endpackage

// ===== sv/rpm_mulmod.sv =====
`timescale 1ns / 1ps
module rpm_mulmod
  import rpm_pkg::*;
#(
  parameter int PIXEL_BITS = 8,
  parameter int OP_BITS    = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OP_BITS-1:0]  a_in,
  input  logic [OP_BITS-1:0]  b_in,
  input  logic [MOD_BITS-1:0] m_in,
  output logic                done,
  output logic [OP_BITS-1:0]  res
);

  localparam int CW = $clog2(OP_BITS + 1);
  localparam int SW = OP_BITS + 2;
  localparam logic [CW-1:0] CNT_INIT = CW'(OP_BITS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [SW-1:0] PIX_MASK = {{(SW-PIXEL_BITS){1'b0}}, {PIXEL_BITS{1'b1}}};

  logic [OP_BITS-1:0]  a_r, a_nxt;
  logic [OP_BITS-1:0]  b_r, b_nxt;
  logic [OP_BITS-1:0]  r_r, r_nxt;
  logic [MOD_BITS-1:0] m_r, m_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [SW-1:0] m_ext;
  logic [SW-1:0] dbl;
  logic [SW-1:0] dbl_red;
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_red;
  logic          m_zero;

  // one multiplier bit per cycle: r = 2r + a_i * b, reduced after each add
  always_comb begin
    m_ext  = SW'(m_r);
    m_zero = (m_r == '0);
    dbl    = {1'b0, r_r, 1'b0};
    if (!m_zero && dbl >= m_ext) begin
      dbl_red = dbl - m_ext;
    end else begin
      dbl_red = dbl;
    end
    sum = dbl_red + (a_r[OP_BITS-1] ? SW'(b_r) : '0);
    if (m_zero) begin
      sum_red = sum & PIX_MASK;
    end else if (sum >= m_ext) begin
      sum_red = sum - m_ext;
    end else begin
      sum_red = sum;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      m_nxt    = m_in;
      r_nxt    = '0;
      cnt_nxt  = CNT_INIT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      a_nxt   = {a_r[OP_BITS-2:0], 1'b0};
      r_nxt   = sum_red[OP_BITS-1:0];
      cnt_nxt = cnt_r - CNT_ONE;
      if (cnt_r == CNT_ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
    m_r <= m_nxt;
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

// ===== sv/rsa_pixel_modexp_top.sv =====
// W = max(PIXEL_BITS, 9) is the operand width of the modular multiplier;
// exponent 0 or 1 passes the pixel straight through with no modular multiply
// one pixel at a time; each modular multiply is a bit-serial pass over W bits
// the next pixel is taken once the result sits in the output register
// synchronous active-low reset: modulus 253, exponent 13, channels empty
`timescale 1ns / 1ps
module rsa_pixel_modexp_top
  import rpm_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIXEL_BITS-1:0]    in_pixel_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PIXEL_BITS-1:0]    out_pixel_out
);

  localparam int OP_BITS = (PIXEL_BITS > MOD_BITS) ? PIXEL_BITS : MOD_BITS;
  localparam logic [OP_BITS-1:0] OP_ONE = OP_BITS'(1);
  localparam logic [MOD_BITS-1:0] MOD_ONE = MOD_BITS'(1);

  rpm_state_t state_r, state_nxt;

  logic [MOD_BITS-1:0]   modulus_r, modulus_nxt;
  logic [EXP_BITS-1:0]   exponent_r, exponent_nxt;
  logic [PIXEL_BITS-1:0] pix_r, pix_nxt;
  logic [PIXEL_BITS-1:0] res_r, res_nxt;
  logic [OP_BITS-1:0]    acc_r, acc_nxt;
  logic [OP_BITS-1:0]    base_r, base_nxt;
  logic [IDX_BITS-1:0]   bit_idx_r, bit_idx_nxt;
  logic                  go_r, go_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PIXEL_BITS-1:0] out_pixel_r, out_pixel_nxt;

  logic               in_beat;
  logic               pass_thru;
  logic               out_free;
  logic               mm_start;
  logic               mm_done;
  logic [OP_BITS-1:0] mm_a;
  logic [OP_BITS-1:0] mm_b;
  logic [OP_BITS-1:0] mm_res;
  logic [OP_BITS-1:0] acc_init;

  assign in_beat   = in_valid && in_ready;
  assign pass_thru = (exponent_r[EXP_BITS-1:1] == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign acc_init  = (modulus_r == MOD_ONE) ? '0 : OP_ONE;

  // config decode
  always_comb begin
    modulus_nxt  = modulus_r;
    exponent_nxt = exponent_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_nxt  = cfg_wdata[MOD_BITS-1:0];
        REG_EXPONENT: exponent_nxt = cfg_wdata[EXP_BITS-1:0];
        default:      modulus_nxt  = modulus_r;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = pass_thru ? ST_DONE : ST_BASE;
      end
      ST_BASE: begin
        if (mm_done) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        if (mm_done) begin
          if (exponent_r[bit_idx_r]) state_nxt = ST_MUL;
          else if (bit_idx_r == '0) state_nxt = ST_DONE;
          else state_nxt = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_done) state_nxt = (bit_idx_r == '0) ? ST_DONE : ST_SQR;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and operand select
  always_comb begin
    in_ready = 1'b0;
    mm_a     = acc_r;
    mm_b     = acc_r;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_BASE: begin
        mm_a = OP_BITS'(pix_r);
        mm_b = OP_ONE;
      end
      ST_SQR:  mm_b = acc_r;
      ST_MUL:  mm_b = base_r;
      ST_DONE: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  assign mm_start = go_r;

  // datapath
  always_comb begin
    pix_nxt     = pix_r;
    res_nxt     = res_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    bit_idx_nxt = bit_idx_r;
    go_nxt      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          pix_nxt = in_pixel_in;
          res_nxt = in_pixel_in;
          go_nxt  = !pass_thru;
        end
      end
      ST_BASE: begin
        if (mm_done) begin
          base_nxt    = mm_res;
          acc_nxt     = acc_init;
          bit_idx_nxt = BIT_IDX_TOP;
          go_nxt      = 1'b1;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          acc_nxt = mm_res;
          if (exponent_r[bit_idx_r]) begin
            go_nxt = 1'b1;
          end else if (bit_idx_r == '0) begin
            res_nxt = mm_res[PIXEL_BITS-1:0];
          end else begin
            bit_idx_nxt = bit_idx_r - 1'b1;
            go_nxt      = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_nxt = mm_res;
          if (bit_idx_r == '0) begin
            res_nxt = mm_res[PIXEL_BITS-1:0];
          end else begin
            bit_idx_nxt = bit_idx_r - 1'b1;
            go_nxt      = 1'b1;
          end
        end
      end
      default: go_nxt = 1'b0;
    endcase
  end

  // output register
  always_comb begin
    out_pixel_nxt = out_pixel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == ST_DONE && out_free) begin
      out_pixel_nxt = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MODULUS_RESET;
      exponent_r  <= EXPONENT_RESET;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      exponent_r  <= exponent_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r       <= pix_nxt;
    res_r       <= res_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    bit_idx_r   <= bit_idx_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  rpm_mulmod #(
    .PIXEL_BITS(PIXEL_BITS),
    .OP_BITS   (OP_BITS)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mm_start),
    .a_in (mm_a),
    .b_in (mm_b),
    .m_in (modulus_r),
    .done (mm_done),
    .res  (mm_res)
  );

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

// ===== sv/rpm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpm_checker #(
  parameter int PIXEL_BITS = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PIXEL_BITS-1:0] out_pixel_out
);

  // a stalled result beat stays put
  `RPM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
  `RPM_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_pixel_out), "out beat changed")

  // one pixel at a time: busy right after a pixel is taken
  `RPM_ASSERT(a_busy_after_in, clk, rst_n, in_valid && in_ready |=> !in_ready, "second pixel taken while busy")

  // reset empties the result channel
  `RPM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind rsa_pixel_modexp_top rpm_checker #(.PIXEL_BITS(PIXEL_BITS)) u_rpm_checker (.*);

// ===== dv/tb_rsa_pixel_modexp_top.sv =====
`timescale 1ns / 1ps
module tb_rsa_pixel_modexp_top;
  import rpm_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 600;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 94;
  localparam int N_DIRECTED = 27;

  typedef enum logic {ROW_SETUP, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [MOD_BITS-1:0]   modulus;
    logic [EXP_BITS-1:0]   exponent;
    logic [7:0]            pixel;
    logic                  typed;
    logic [7:0]            want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd1,   1'b1, 8'd1},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd255, 1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd128, 1'b0, 8'd0},
    '{ROW_SETUP, 9'd253, 8'd0,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd255, 1'b1, 8'd255},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{ROW_SETUP, 9'd253, 8'd1,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd254, 1'b1, 8'd254},
    '{ROW_SETUP, 9'd1,   8'd2,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd200, 1'b1, 8'd0},
    '{ROW_SETUP, 9'd0,   8'd2,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd16,  1'b1, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd3,   1'b1, 8'd9},
    '{ROW_SETUP, 9'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd255, 1'b1, 8'd255},
    '{ROW_SETUP, 9'd300, 8'd2,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd17,  1'b1, 8'd33},
    '{ROW_SETUP, 9'd511, 8'd2,   8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd255, 1'b0, 8'd0},
    '{ROW_SETUP, 9'd256, 8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd3,   1'b0, 8'd0},
    '{ROW_SETUP, 9'd2,   8'd255, 8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd255, 1'b1, 8'd1},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd254, 1'b1, 8'd0},
    '{ROW_SETUP, 9'd253, 8'd17,  8'd0,   1'b0, 8'd0},
    '{ROW_PIXEL, 9'd0,   8'd0,   8'd42,  1'b0, 8'd0}
  };

  localparam logic [MOD_BITS-1:0] PHASE_MOD [7] = '{9'd253, 9'd2, 9'd256, 9'd511,
                                                    9'd0, 9'd1, 9'd300};
  localparam logic [EXP_BITS-1:0] PHASE_EXP [7] = '{8'd13, 8'd255, 8'd255, 8'd2,
                                                    8'd255, 8'd3, 8'd1};

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [7:0]               in_pixel_in;
  logic                     out_valid;
  logic                     out_ready;
  logic [7:0]               out_pixel_out;

  logic [MOD_BITS-1:0] cur_modulus;
  logic [EXP_BITS-1:0] cur_exponent;
  logic [7:0]          decrypted_due [$];
  int                  mismatch_count;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_requests;
  int                  hold_served;
  int                  hold_left;

  rsa_pixel_modexp_top #(
    .PIXEL_BITS(8)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rsa_decrypt(input logic [7:0] pix,
                                             input logic [MOD_BITS-1:0] n,
                                             input logic [EXP_BITS-1:0] d);
    int unsigned acc;
    int unsigned base;
    if (d < 2) return pix;
    acc = (n == 0) ? 1 : (1 % n);
    base = (n == 0) ? pix : (pix % n);
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (n == 0) ? ((acc * acc) & 8'hff) : ((acc * acc) % n);
      if (d[i]) begin
        acc = (n == 0) ? ((acc * base) & 8'hff) : ((acc * base) % n);
      end
    end
    return acc[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // beat is taken at the edge where in_ready is seen high; valid may drop at random between beats
  task automatic send_pixel(input logic [7:0] pix, input logic [7:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    decrypted_due = {decrypted_due, want};
  endtask

  task automatic apply_config(input logic [MOD_BITS-1:0] n, input logic [EXP_BITS-1:0] d);
    in_valid <= 1'b0;
    while (decrypted_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_index <= REG_EXPONENT;
    cfg_wdata <= CFG_DATA_BITS'(d);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_modulus = n;
    cur_exponent = d;
  endtask

  // result side: check each beat, then pick ready for the next edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (decrypted_due.size() == 0) begin
          report_mismatch("unexpected pixel_out", out_pixel_out, -1);
        end else if (out_pixel_out !== decrypted_due[0]) begin
          report_mismatch("pixel_out", out_pixel_out, decrypted_due.pop_front());
        end else begin
          void'(decrypted_due.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t  row;
    logic [7:0] pix;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    cur_modulus = MODULUS_RESET;
    cur_exponent = EXPONENT_RESET;
    send_idle_pct = 21;
    recv_idle_pct = 50;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_SETUP) begin
        apply_config(row.modulus, row.exponent);
      end else if (row.typed) begin
        send_pixel(row.pixel, row.want);
      end else begin
        send_pixel(row.pixel, rsa_decrypt(row.pixel, cur_modulus, cur_exponent));
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 21;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph < 7) begin
        apply_config(PHASE_MOD[ph], PHASE_EXP[ph]);
      end else begin
        apply_config(MOD_BITS'($urandom_range(2, 256)), EXP_BITS'($urandom_range(0, 255)));
      end
      // long output stall while inputs keep coming
      if (ph == 9) hold_requests++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pix = 8'($urandom_range(0, 255));
        send_pixel(pix, rsa_decrypt(pix, cur_modulus, cur_exponent));
      end
    end

    in_valid <= 1'b0;
    while (decrypted_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
